// File: design/cicmd_pkg.sv
// ----------------------------------------------------------------------------
// cicmd_pkg
// Shared types, widths and codes for the cloud-in-cell deposition block.
// ----------------------------------------------------------------------------
package cicmd_pkg;

  // Default grid dimensions.
  localparam int GRID_X_DEF = 128;
  localparam int GRID_Y_DEF = 128;

  // Field widths.
  localparam int POS_W      = 32;
  localparam int IDX_W      = 7;
  localparam int VAL_W      = 32;
  localparam int INV_W      = 24;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int S_TDATA_W  = 80;
  localparam int M_TDATA_W  = 32;

  // Grid coordinate in Q.32: product of 33 by 25 bits plus the half-grid offset.
  localparam int DIFF_W = POS_W + 1;
  localparam int PROD_W = DIFF_W + INV_W + 1;
  localparam int V_W    = 60;
  localparam int CELL_W = V_W - 1 - 32;
  // Wide enough to compare a read index with a grid size up to 4096.
  localparam int CMP_W  = 13;
  // Bilinear weight, 0..65536.
  localparam int WGT_W  = FRAC_W + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL = 2'd2;

  localparam logic [INV_W-1:0] INV_RESET = 24'd65536;

  // Values of the action field.
  localparam logic ACT_DEPOSIT = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_LOC_Y,
    ST_CHECK,
    ST_MEM_FIRST,
    ST_MEM_MID,
    ST_MEM_LAST,
    ST_RD_CELL,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic       load;     // capture the accepted input item
    logic       clr_en;   // clear one grid cell and advance the sweep
    logic       mul_en;   // register the scaled offset
    logic       mul_y;    // multiplier works on the y axis
    logic       loc_en;   // register cell index and fraction
    logic       loc_y;    // locate works on the y axis
    logic       rd_en;    // read one grid cell
    logic       rd_item;  // read address comes from the read item
    logic [1:0] rd_idx;   // corner of the 2x2 footprint being read
    logic       wr_en;    // write back the corner read last
    logic       res_load; // load the result register
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_grid;
  } status_t;

endpackage

// File: design/cic_mass_deposit_grid_top.sv
// ----------------------------------------------------------------------------
// cic_mass_deposit_grid_top
// A deposit runs from accept to result through two multiplier passes, locate
// and check, then, on the grid, a read-modify-write of the four corners on the
// grid memory port. A new item is accepted in the cycle after the previous one
// is handed to the result register, so items are handled one at a time. After
// reset a clearing sweep writes zeros to all GRID_X*GRID_Y cells before the
// first item is accepted; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module cic_mass_deposit_grid_top
  import cicmd_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: pos_x[31:0], pos_y[63:32], read_row[70:64],
  // read_col[77:71], zero padding[79:78].
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: action.
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: cell_value[31:0].
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // Fields from bit 0: in_range.
  output logic                  m_axis_tuser
);

  cmd_t    cmd;
  status_t status;

  cicmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_action_i (s_axis_tuser),
    .s_ready_o  (s_axis_tready),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cicmd_datapath #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_data_i     (s_axis_tdata),
    .s_action_i   (s_axis_tuser),
    .cmd_i        (cmd),
    .status_o     (status),
    .cell_value_o (m_axis_tdata),
    .in_range_o   (m_axis_tuser)
  );

endmodule

// File: design/cicmd_ctrl.sv
// ----------------------------------------------------------------------------
// cicmd_ctrl
// Sequencer: clearing sweep, per-axis scaling, four-corner read-modify-write,
// single-cell read and hand-off to the result register.
// ----------------------------------------------------------------------------
module cicmd_ctrl
  import cicmd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_valid_i,
  input  logic    s_action_i,
  output logic    s_ready_o,
  input  logic    m_ready_i,
  output logic    m_valid_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] k_q, k_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = (s_action_i == ACT_READ) ? ST_RD_CELL : ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        cmd_o.mul_en = 1'b1;
        state_d = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_y  = 1'b1;
        cmd_o.loc_en = 1'b1;
        state_d = ST_LOC_Y;
      end
      ST_LOC_Y: begin
        cmd_o.loc_en = 1'b1;
        cmd_o.loc_y  = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = status_i.in_grid ? ST_MEM_FIRST : ST_FINISH;
      end
      ST_MEM_FIRST: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_idx = 2'd0;
        k_d = 2'd1;
        state_d = ST_MEM_MID;
      end
      ST_MEM_MID: begin
        // Write back the previous corner while the next one is read.
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_idx = k_q;
        cmd_o.wr_en  = 1'b1;
        if (k_q == 2'd3) begin
          state_d = ST_MEM_LAST;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      ST_MEM_LAST: begin
        cmd_o.wr_en = 1'b1;
        state_d = ST_FINISH;
      end
      ST_RD_CELL: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_item = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || m_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

// File: design/cicmd_datapath.sv
// ----------------------------------------------------------------------------
// cicmd_datapath
// Configuration registers, coordinate scaling, bilinear weights, density grid
// memory with saturating accumulate, and the result register.
// ----------------------------------------------------------------------------
module cicmd_datapath
  import cicmd_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [S_TDATA_W-1:0]  s_data_i,
  input  logic                  s_action_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic [VAL_W-1:0]      cell_value_o,
  output logic                  in_range_o
);

  localparam int DEPTH = GRID_X * GRID_Y;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int YW    = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam logic signed [V_W-1:0] HALF_X = V_W'(GRID_X) <<< 31;
  localparam logic signed [V_W-1:0] HALF_Y = V_W'(GRID_Y) <<< 31;
  localparam logic [CELL_W-1:0] LIMIT_X = CELL_W'(GRID_X - 2);
  localparam logic [CELL_W-1:0] LIMIT_Y = CELL_W'(GRID_Y - 2);

  // Configuration.
  logic signed [POS_W-1:0] origin_x_q, origin_y_q;
  logic [INV_W-1:0]        inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      inv_q      <= INV_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X: origin_x_q <= cfg_data_i[POS_W-1:0];
        CFG_ORIGIN_Y: origin_y_q <= cfg_data_i[POS_W-1:0];
        CFG_INV_CELL: inv_q      <= cfg_data_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured input item.
  logic signed [POS_W-1:0] pos_x_q, pos_y_q;
  logic [IDX_W-1:0]        row_q, col_q;
  logic                    is_read_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_x_q   <= s_data_i[POS_W-1:0];
      pos_y_q   <= s_data_i[2*POS_W-1:POS_W];
      row_q     <= s_data_i[2*POS_W+IDX_W-1:2*POS_W];
      col_q     <= s_data_i[2*POS_W+2*IDX_W-1:2*POS_W+IDX_W];
      is_read_q <= (s_action_i == ACT_READ);
    end
  end

  // Shared multiplier for (pos - origin) * inv_cell_size, one axis per cycle.
  logic signed [DIFF_W-1:0] diff;
  logic signed [INV_W:0]    inv_s;
  logic signed [PROD_W-1:0] prod, prod_q;

  assign diff  = cmd_i.mul_y ? (DIFF_W'(pos_y_q) - DIFF_W'(origin_y_q))
                             : (DIFF_W'(pos_x_q) - DIFF_W'(origin_x_q));
  assign inv_s = $signed({1'b0, inv_q});
  assign prod  = diff * inv_s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= prod;
  end

  // Locate: add the half-grid offset, split into cell and fraction.
  logic signed [V_W-1:0] v;
  logic [CELL_W-1:0]     v_cell;
  logic                  v_ok;
  logic [XW-1:0]         cell_x_q;
  logic [YW-1:0]         cell_y_q;
  logic [FRAC_W-1:0]     frac_x_q, frac_y_q;
  logic                  ok_x_q, ok_y_q;

  assign v      = V_W'(prod_q) + (cmd_i.loc_y ? HALF_Y : HALF_X);
  assign v_cell = v[V_W-2:32];
  assign v_ok   = !v[V_W-1] && (v_cell <= (cmd_i.loc_y ? LIMIT_Y : LIMIT_X));

  always_ff @(posedge clk_i) begin
    if (cmd_i.loc_en) begin
      if (cmd_i.loc_y) begin
        cell_y_q <= v[32+YW-1:32];
        frac_y_q <= v[31:16];
        ok_y_q   <= v_ok;
      end else begin
        cell_x_q <= v[32+XW-1:32];
        frac_x_q <= v[31:16];
        ok_x_q   <= v_ok;
      end
    end
  end

  assign status_o.in_grid = ok_x_q && ok_y_q;

  // Corner weight: the low index bit picks the y side, the high bit the x side.
  logic [WGT_W-1:0]     wgt_a, wgt_b, wgt;
  logic [2*WGT_W-1:0]   wgt_prod;

  assign wgt_a    = cmd_i.rd_idx[1] ? WGT_W'(frac_x_q) : (WGT_W'(65536) - WGT_W'(frac_x_q));
  assign wgt_b    = cmd_i.rd_idx[0] ? WGT_W'(frac_y_q) : (WGT_W'(65536) - WGT_W'(frac_y_q));
  assign wgt_prod = (2*WGT_W)'(wgt_a) * (2*WGT_W)'(wgt_b) + (2*WGT_W)'(32768);
  assign wgt      = wgt_prod[FRAC_W+WGT_W-1:FRAC_W];

  // Addresses.
  logic [XW-1:0] corner_x;
  logic [YW-1:0] corner_y;
  logic [AW-1:0] dep_addr, item_addr, rd_addr;
  logic          item_ok;

  assign corner_x  = cell_x_q + XW'(cmd_i.rd_idx[1]);
  assign corner_y  = cell_y_q + YW'(cmd_i.rd_idx[0]);
  assign dep_addr  = AW'(corner_x) * AW'(GRID_Y) + AW'(corner_y);
  assign item_addr = AW'(row_q) * AW'(GRID_Y) + AW'(col_q);
  assign item_ok   = (CMP_W'(row_q) < CMP_W'(GRID_X)) && (CMP_W'(col_q) < CMP_W'(GRID_Y));
  assign rd_addr   = cmd_i.rd_item ? item_addr : dep_addr;

  logic [AW-1:0]    wr_addr_q;
  logic [WGT_W-1:0] wgt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en && !cmd_i.rd_item) begin
      wr_addr_q <= dep_addr;
      wgt_q     <= wgt;
    end
  end

  // Clearing sweep after reset.
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  assign status_o.clr_last = (clr_addr_q == AW'(DEPTH - 1));

  // Saturating accumulate of the cell read in the previous cycle.
  logic [VAL_W-1:0] rd_q;
  logic [VAL_W:0]   acc;
  logic [VAL_W-1:0] acc_sat;

  assign acc     = {1'b0, rd_q} + (VAL_W+1)'(wgt_q);
  assign acc_sat = acc[VAL_W] ? {VAL_W{1'b1}} : acc[VAL_W-1:0];

  // Density grid: one write and one read port.
  logic [VAL_W-1:0] grid_mem [DEPTH];
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_wa;
  logic [VAL_W-1:0] mem_wd;

  assign mem_we = cmd_i.clr_en || cmd_i.wr_en;
  assign mem_wa = cmd_i.clr_en ? clr_addr_q : wr_addr_q;
  assign mem_wd = cmd_i.clr_en ? '0 : acc_sat;
  assign mem_re = cmd_i.rd_en && (!cmd_i.rd_item || item_ok);

  always_ff @(posedge clk_i) begin
    if (mem_we) grid_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= grid_mem[rd_addr];
  end

  // Result register.
  logic [VAL_W-1:0] res_value_q;
  logic             res_range_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      if (is_read_q) begin
        res_value_q <= item_ok ? rd_q : '0;
        res_range_q <= item_ok;
      end else begin
        res_value_q <= '0;
        res_range_q <= ok_x_q && ok_y_q;
      end
    end
  end

  assign cell_value_o = res_value_q;
  assign in_range_o   = res_range_q;

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cloud-in-cell deposition block. A directed
// table and then random deposit and read transactions are driven under
// several origin and scale settings. A bit-accurate mirror of the density
// grid predicts results the table does not fix; a scoreboard checks in order.
// ----------------------------------------------------------------------------
module tb;
  import cicmd_pkg::*;

  localparam int GRID_X = GRID_X_DEF;
  localparam int GRID_Y = GRID_Y_DEF;

  // The block has no register at this index, so writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  typedef enum logic [1:0] {
    ROW_DEPOSIT,
    ROW_READ,
    ROW_CONFIG
  } row_kind_e;

  // For a config row, pos_a and pos_b carry origin_x and origin_y.
  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] pos_a;
    logic [31:0] pos_b;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [23:0] inv;
    logic        typed;
    logic [31:0] val;
    logic        rng;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] value;
    logic        in_range;
  } cell_report_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;

  cic_mass_deposit_grid_top #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Mirror of the block state.
  logic [31:0]  grid_mirror [GRID_X*GRID_Y];
  longint       mirror_org_x;
  longint       mirror_org_y;
  logic [23:0]  mirror_inv;
  int           hot_i;
  int           hot_j;

  cell_report_t cell_reports_q [$];
  stim_row_t    stim_table [$];
  int           fail_cnt;
  int           send_idle_pct;
  int           take_idle_pct;
  int           hold_seq;
  int           hold_seen;
  int           hold_left;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic stim_row_t tab(input row_kind_e kind, input logic [31:0] a,
                                    input logic [31:0] b, input logic [6:0] row,
                                    input logic [6:0] col, input logic [23:0] inv,
                                    input logic typed, input logic [31:0] val,
                                    input logic rng);
    stim_row_t r;
    r = '{kind, a, b, row, col, inv, typed, val, rng};
    return r;
  endfunction

  // Maps one coordinate into Q.32 grid space; returns 0 when off the grid.
  function automatic bit grid_locate(input logic [31:0] pos, input longint org,
                                     input int n, output int cell_no, output longint frac);
    longint v;
    v = (longint'($signed(pos)) - org) * longint'(mirror_inv)
        + longint'(n) * 64'sd2147483648;
    cell_no = 0;
    frac = 0;
    if (v < 0) return 1'b0;
    if ((v >>> 32) > longint'(n - 2)) return 1'b0;
    cell_no = int'(v >>> 32);
    frac = (v >>> 16) & 64'sh0FFFF;
    return 1'b1;
  endfunction

  function automatic void cell_add(input int idx, input longint w);
    longint s;
    s = longint'(grid_mirror[idx]) + w;
    grid_mirror[idx] = (s > 64'sh0FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic cell_report_t cic_predict(input logic act, input logic [31:0] px,
                                               input logic [31:0] py, input logic [6:0] r,
                                               input logic [6:0] c);
    cell_report_t res;
    int           i;
    int           j;
    longint       fx;
    longint       fy;
    longint       wx;
    longint       wy;
    res.value    = '0;
    res.in_range = 1'b0;
    if (act == ACT_READ) begin
      if (r < GRID_X && c < GRID_Y) begin
        res.value    = grid_mirror[r * GRID_Y + c];
        res.in_range = 1'b1;
      end
      return res;
    end
    if (!grid_locate(px, mirror_org_x, GRID_X, i, fx)) return res;
    if (!grid_locate(py, mirror_org_y, GRID_Y, j, fy)) return res;
    wx = 65536 - fx;
    wy = 65536 - fy;
    cell_add(i * GRID_Y + j, (wx * wy + 32768) >>> 16);
    cell_add(i * GRID_Y + j + 1, (wx * fy + 32768) >>> 16);
    cell_add((i + 1) * GRID_Y + j, (fx * wy + 32768) >>> 16);
    cell_add((i + 1) * GRID_Y + j + 1, (fx * fy + 32768) >>> 16);
    hot_i = i;
    hot_j = j;
    res.in_range = 1'b1;
    return res;
  endfunction

  // Picks a position that mostly lands on the grid under the current scale.
  function automatic logic [31:0] aim_pos(input logic [31:0] org);
    longint          span;
    longint unsigned r;
    longint unsigned m;
    longint          t;
    if (mirror_inv == 0) return $urandom;
    span = (longint'(64) <<< 32) / longint'(mirror_inv);
    span = span + span / 8 + 1;
    if (span > 64'sh1_0000_0000) return $urandom;
    r = {$urandom, $urandom};
    m = 2 * span + 1;
    t = r % m;
    t = t - span;
    return org + t[31:0];
  endfunction

  // Offers one transaction and returns at the edge where it was accepted.
  task automatic offer(input logic act, input logic [31:0] px, input logic [31:0] py,
                       input logic [6:0] r, input logic [6:0] c, input logic typed,
                       input logic [31:0] tv, input logic tr);
    int           gap;
    cell_report_t pred;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, c, r, py, px};
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = cic_predict(act, px, py, r, c);
    if (typed) begin
      pred.value    = tv;
      pred.in_range = tr;
    end
    cell_reports_q.push_back(pred);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (cell_reports_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_apply(input logic [31:0] ox, input logic [31:0] oy,
                           input logic [31:0] inv_word);
    for (int k = 0; k < 4; k++) begin
      cfg_we_i <= 1'b1;
      case (k)
        0: begin
          cfg_idx_i  <= CFG_ORIGIN_X;
          cfg_data_i <= ox;
        end
        1: begin
          cfg_idx_i  <= CFG_ORIGIN_Y;
          cfg_data_i <= oy;
        end
        2: begin
          cfg_idx_i  <= CFG_INV_CELL;
          cfg_data_i <= inv_word;
        end
        default: begin
          cfg_idx_i  <= CFG_NONE;
          cfg_data_i <= $urandom;
        end
      endcase
      @(posedge clk_i);
    end
    cfg_we_i     <= 1'b0;
    mirror_org_x = longint'($signed(ox));
    mirror_org_y = longint'($signed(oy));
    mirror_inv   = inv_word[23:0];
  endtask

  // Result side: scoreboard check, random stalls and the long hold-off.
  always @(posedge clk_i) begin : take_side
    cell_report_t want;
    logic         rdy;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cell_reports_q.size() == 0) begin
        $error("unexpected result: cell_value %h, in_range %b", m_axis_tdata, m_axis_tuser);
        fail_cnt++;
      end else begin
        want = cell_reports_q.pop_front();
        if (m_axis_tdata !== want.value) begin
          $error("cell_value: expected %h, got %h", want.value, m_axis_tdata);
          fail_cnt++;
        end
        if (m_axis_tuser !== want.in_range) begin
          $error("in_range: expected %b, got %b", want.in_range, m_axis_tuser);
          fail_cnt++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rdy = 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = 300;
      rdy = 1'b0;
    end else begin
      rdy = !(take_idle_pct != 0 && $urandom_range(99) < take_idle_pct);
    end
    m_axis_tready <= rdy;
  end

  initial begin
    #40_000_000;
    $display("** cic_mass_deposit_grid_top: FAILED **");
    $finish;
  end

  initial begin
    logic        act;
    logic [31:0] px;
    logic [31:0] py;
    logic [6:0]  r;
    logic [6:0]  c;
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] inv_word;
    int          pick;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ORIGIN_X;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_DEPOSIT;
    m_axis_tready = 1'b0;
    fail_cnt      = 0;
    hold_seq      = 0;
    hold_seen     = 0;
    hold_left     = 0;
    hot_i         = GRID_X / 2;
    hot_j         = GRID_Y / 2;
    mirror_org_x  = 0;
    mirror_org_y  = 0;
    mirror_inv    = INV_RESET;
    send_idle_pct = 33;
    take_idle_pct = 67;
    foreach (grid_mirror[k]) grid_mirror[k] = '0;

    // At unit scale and zero origin, position p lands in cell floor(p) + 64.
    stim_table.push_back(tab(ROW_READ,    '0,           '0,            0,   0,   0, 1, 0, 1));
    stim_table.push_back(tab(ROW_READ,    '0,           '0,            127, 127, 0, 1, 0, 1));
    stim_table.push_back(tab(ROW_DEPOSIT, 32'h0,        32'h0,         0,   0,   0, 1, 0, 1));
    stim_table.push_back(tab(ROW_READ,    '0,           '0,            64,  64,  0, 1,
                             32'h0001_0000, 1));
    stim_table.push_back(tab(ROW_READ,    '0,           '0,            64,  65,  0, 1, 0, 1));
    stim_table.push_back(tab(ROW_DEPOSIT, 32'hFFC0_0000, 32'hFFC0_0000, 0,  0,   0, 1, 0, 1));
    stim_table.push_back(tab(ROW_READ,    '0,           '0,            0,   0,   0, 1,
                             32'h0001_0000, 1));
    stim_table.push_back(tab(ROW_DEPOSIT, 32'h003E_FFFF, 32'h003E_FFFF, 0,  0,   0, 1, 0, 1));
    stim_table.push_back(tab(ROW_READ,    '0,           '0,            127, 127, 0, 0, 0, 0));
    // Right edge, slightly negative coordinate, and full-scale positions.
    stim_table.push_back(tab(ROW_DEPOSIT, 32'h003F_0000, 32'h0,        0,   0,   0, 1, 0, 0));
    stim_table.push_back(tab(ROW_DEPOSIT, 32'h0,        32'hFFBF_FFFF, 0,   0,   0, 1, 0, 0));
    stim_table.push_back(tab(ROW_DEPOSIT, 32'h7FFF_FFFF, 32'h8000_0000, 0,  0,   0, 1, 0, 0));
    stim_table.push_back(tab(ROW_DEPOSIT, 32'h8000_0000, 32'h7FFF_FFFF, 0,  0,   0, 1, 0, 0));
    stim_table.push_back(tab(ROW_DEPOSIT, 32'h0000_8000, 32'h0000_8000, 0,  0,   0, 0, 0, 0));
    stim_table.push_back(tab(ROW_READ,    '0,           '0,            65,  65,  0, 0, 0, 0));
    stim_table.push_back(tab(ROW_READ,    '0,           '0,            64,  64,  0, 0, 0, 0));
    stim_table.push_back(tab(ROW_CONFIG,  32'h0010_0000, 32'hFFF0_0000, 0,  0,
                             24'h02_0000, 0, 0, 0));
    stim_table.push_back(tab(ROW_DEPOSIT, 32'h0010_0000, 32'hFFF0_0000, 0,  0,   0, 1, 0, 1));
    stim_table.push_back(tab(ROW_DEPOSIT, 32'h0030_0000, 32'h0,        0,   0,   0, 1, 0, 0));
    // A zero reciprocal sends every particle to the grid center.
    stim_table.push_back(tab(ROW_CONFIG,  32'h7FFF_FFFF, 32'h8000_0000, 0,  0,   0, 0, 0, 0));
    stim_table.push_back(tab(ROW_DEPOSIT, 32'h1234_5678, 32'hFEDC_BA98, 0,  0,   0, 1, 0, 1));
    stim_table.push_back(tab(ROW_READ,    '0,           '0,            64,  64,  0, 0, 0, 0));
    stim_table.push_back(tab(ROW_CONFIG,  32'h0,        32'h0,         0,   0,
                             24'h01_0000, 0, 0, 0));
    stim_table.push_back(tab(ROW_READ,    '0,           '0,            127, 0,   0, 0, 0, 0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_table[n]) begin
      if (stim_table[n].kind == ROW_CONFIG) begin
        settle();
        cfg_apply(stim_table[n].pos_a, stim_table[n].pos_b, {8'h00, stim_table[n].inv});
      end else begin
        offer((stim_table[n].kind == ROW_READ) ? ACT_READ : ACT_DEPOSIT,
              stim_table[n].pos_a, stim_table[n].pos_b, stim_table[n].row,
              stim_table[n].col, stim_table[n].typed, stim_table[n].val,
              stim_table[n].rng);
      end
    end

    // Repeated full-weight deposits on one untouched cell add up exactly,
    // and a centered particle adds a quarter weight on top.
    settle();
    cfg_apply(32'h0, 32'h0, 32'h0001_0000);
    repeat (40) offer(ACT_DEPOSIT, 32'h000A_0000, 32'hFFEC_0000, 0, 0, 0, 0, 0);
    offer(ACT_DEPOSIT, 32'h000A_8000, 32'hFFEC_8000, 0, 0, 0, 0, 0);
    offer(ACT_READ, 32'h0, 32'h0, 74, 44, 1, 32'h0028_4000, 1);

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin
          ox = 32'h0;
          oy = 32'h0;
          inv_word = {8'hA5, 24'h01_0000};
        end
        1: begin
          ox = $urandom;
          oy = $urandom;
          inv_word = 32'h0000_4000;
        end
        2: begin
          ox = 32'h7FFF_FFFF;
          oy = 32'h8000_0000;
          inv_word = 32'h00FF_FFFF;
        end
        3: begin
          ox = 32'h8000_0000;
          oy = 32'h7FFF_FFFF;
          inv_word = 32'h0000_0001;
        end
        4: begin
          ox = $urandom;
          oy = $urandom;
          inv_word = {8'($urandom_range(255)),
                      24'(int'($urandom_range(24'hFF_FFFF, 1)))};
        end
        default: begin
          ox = $urandom;
          oy = 32'h0;
          inv_word = {8'($urandom_range(255)), 24'h0};
        end
      endcase
      cfg_apply(ox, oy, inv_word);
      send_idle_pct <= (p < 2) ? 33 : (p < 4) ? 67 : 0;
      take_idle_pct <= (p < 2) ? 67 : (p < 4) ? 33 : 0;

      for (int k = 0; k < 175; k++) begin
        if (p == 1 && k == 60) hold_seq <= hold_seq + 1;
        if (p == 3 && k == 90) settle();
        px = $urandom;
        py = $urandom;
        r  = 7'($urandom);
        c  = 7'($urandom);
        act = ($urandom_range(99) < 35) ? ACT_READ : ACT_DEPOSIT;
        if (act == ACT_READ) begin
          if ($urandom_range(99) < 60) begin
            r = 7'(hot_i + $urandom_range(1));
            c = 7'(hot_j + $urandom_range(1));
          end
        end else begin
          pick = $urandom_range(99);
          if (pick < 75) begin
            px = aim_pos(ox);
            py = aim_pos(oy);
          end else if (pick >= 90) begin
            case ($urandom_range(4))
              0: px = 32'h0;
              1: px = 32'h7FFF_FFFF;
              2: px = 32'h8000_0000;
              3: px = 32'hFFFF_FFFF;
              default: px = ox;
            endcase
            py = ($urandom_range(1) != 0) ? oy : aim_pos(oy);
          end
        end
        offer(act, px, py, r, c, 0, 0, 0);
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("** cic_mass_deposit_grid_top: PASSED **");
    end else begin
      $display("** cic_mass_deposit_grid_top: FAILED **");
    end
    $finish;
  end

endmodule
